// File: hw/rtl/mpqs_pkg.sv
// ----------------------------------------------------------------------------
// mpqs_pkg
// Shared item types and codes for the stable minimum priority queue.
// ----------------------------------------------------------------------------
package mpqs_pkg;

	typedef enum logic {
		CMD_ENQUEUE = 1'b0,
		CMD_DEQUEUE = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		ST_ENQUEUED = 2'd0,
		ST_DEQUEUED = 2'd1,
		ST_EMPTY    = 2'd2,
		ST_FULL     = 2'd3
	} status_t;

	localparam int PAYLOAD_W = 32;
	localparam int RANK_W    = 8;
	localparam int OCC_W     = 5;

	typedef struct packed {
		cmd_t                        command;
		logic signed [PAYLOAD_W-1:0] payload;
		logic [RANK_W-1:0]           rank;
	} in_item_t;

	typedef struct packed {
		status_t                     status;
		logic signed [PAYLOAD_W-1:0] out_payload;
		logic [RANK_W-1:0]           out_rank;
		logic [OCC_W-1:0]            occupancy;
	} out_item_t;

endpackage

// File: hw/rtl/min_priority_queue_stable.sv
// ----------------------------------------------------------------------------
// min_priority_queue_stable
// Bounded priority queue kept as an unsorted list in arrival order.
// ----------------------------------------------------------------------------
// Enqueue appends at the tail; dequeue returns the entry with the smallest
// rank, the oldest one among equals, and the entries behind it move up one
// slot. The entries live in a single-port-read memory and one comparator
// walks them. Enqueue, refused enqueue and dequeue on empty pass through
// S_EXEC and S_FINISH to a result in the output register. A dequeue scans
// every held entry in S_SCAN and then, in S_MOVE, moves each entry behind
// the winner up, read then write, through the one memory port pair.
// The input opens again in the cycle after the result is handed to the
// output register. Input is stalled while an item is in work, and the next
// item is taken while a result still waits for the consumer. No clearing
// pass is needed after reset.
module min_priority_queue_stable import mpqs_pkg::*; #(
	parameter int CAPACITY  = 16,
	parameter int RANK_BITS = 8
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_stall,
	input  in_item_t  req,
	output logic      rsp_valid,
	input  logic      rsp_stall,
	output out_item_t rsp
);

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int EW = PAYLOAD_W + RANK_BITS;

	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [EW-1:0] mem_wdata;
	logic [AW-1:0] mem_raddr;
	logic [EW-1:0] mem_rdata;

	logic      res_valid;
	logic      res_ready;
	out_item_t res;

	logic      valid_q;
	out_item_t rsp_q;

	mpqs_store #(
		.DEPTH(CAPACITY),
		.WIDTH(EW),
		.AW   (AW)
	) u_store (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	mpqs_ctrl #(
		.CAPACITY (CAPACITY),
		.RANK_BITS(RANK_BITS),
		.AW       (AW),
		.CW       (CW)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res      (res),
		.mem_we   (mem_we),
		.mem_waddr(mem_waddr),
		.mem_wdata(mem_wdata),
		.mem_raddr(mem_raddr),
		.mem_rdata(mem_rdata)
	);

	// output register, refilled in the cycle it is taken
	assign res_ready = !valid_q || !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (res_ready) begin
			valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			rsp_q <= res;
		end
	end

	assign rsp_valid = valid_q;
	assign rsp       = rsp_q;

endmodule

// File: hw/rtl/mpqs_store.sv
// ----------------------------------------------------------------------------
// mpqs_store
// Entry store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module mpqs_store #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 40,
	parameter int AW    = 4
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: hw/rtl/mpqs_ctrl.sv
// ----------------------------------------------------------------------------
// mpqs_ctrl
// Command sequencer: appends on enqueue, scans with one comparator and then
// closes the gap entry by entry on dequeue.
// ----------------------------------------------------------------------------
module mpqs_ctrl import mpqs_pkg::*; #(
	parameter int CAPACITY  = 16,
	parameter int RANK_BITS = 8,
	parameter int AW        = 4,
	parameter int CW        = 5
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           req_valid,
	output logic                           req_stall,
	input  in_item_t                       req,
	output logic                           res_valid,
	input  logic                           res_ready,
	output out_item_t                      res,
	output logic                           mem_we,
	output logic [AW-1:0]                  mem_waddr,
	output logic [PAYLOAD_W+RANK_BITS-1:0] mem_wdata,
	output logic [AW-1:0]                  mem_raddr,
	input  logic [PAYLOAD_W+RANK_BITS-1:0] mem_rdata
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_SCAN,
		S_MOVE,
		S_FINISH
	} state_t;

	state_t    state_q;
	logic [CW-1:0] fill_q;
	out_item_t res_q;

	cmd_t                 cmd_q;
	logic [PAYLOAD_W-1:0] payload_q;
	logic [RANK_BITS-1:0] rank_q;
	logic [AW-1:0]        cmp_idx_q;
	logic                 first_q;
	logic [AW-1:0]        best_idx_q;
	logic [RANK_BITS-1:0] best_rank_q;
	logic [PAYLOAD_W-1:0] best_payload_q;
	logic [CW-1:0]        rdp_q;
	logic [AW-1:0]        wrp_q;
	logic                 pend_q;

	logic [RANK_BITS-1:0] rd_rank;
	logic [PAYLOAD_W-1:0] rd_payload;
	logic                 take;
	logic [AW-1:0]        nb_idx;
	logic [RANK_BITS-1:0] nb_rank;
	logic [PAYLOAD_W-1:0] nb_payload;
	logic                 full;
	logic                 scan_last;
	logic                 move_done;

	assign rd_rank    = mem_rdata[RANK_BITS-1:0];
	assign rd_payload = mem_rdata[PAYLOAD_W+RANK_BITS-1:RANK_BITS];

	// strict compare keeps the oldest entry on equal ranks
	assign take       = first_q || (rd_rank < best_rank_q);
	assign nb_idx     = take ? cmp_idx_q  : best_idx_q;
	assign nb_rank    = take ? rd_rank    : best_rank_q;
	assign nb_payload = take ? rd_payload : best_payload_q;

	assign full      = (fill_q == CW'(CAPACITY));
	assign scan_last = (CW'(cmp_idx_q) == fill_q - CW'(1));
	assign move_done = (rdp_q >= fill_q);

	assign req_stall = (state_q != S_IDLE);
	assign res_valid = (state_q == S_FINISH);
	assign res       = res_q;

	always_comb begin
		unique case (state_q)
			S_SCAN:  mem_raddr = cmp_idx_q + AW'(1);
			S_MOVE:  mem_raddr = rdp_q[AW-1:0];
			default: mem_raddr = '0;
		endcase
	end

	assign mem_we = ((state_q == S_EXEC) && (cmd_q == CMD_ENQUEUE) && !full) ||
	                ((state_q == S_MOVE) && pend_q);
	assign mem_waddr = (state_q == S_EXEC) ? fill_q[AW-1:0] : wrp_q;
	assign mem_wdata = (state_q == S_EXEC) ? {payload_q, rank_q} : mem_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			fill_q  <= '0;
			res_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (cmd_q == CMD_ENQUEUE) begin
						if (full) begin
							res_q <= '{ST_FULL, '0, '0, OCC_W'(fill_q)};
						end else begin
							fill_q <= fill_q + CW'(1);
							res_q  <= '{ST_ENQUEUED, '0, '0, OCC_W'(fill_q + CW'(1))};
						end
						state_q <= S_FINISH;
					end else if (fill_q == '0) begin
						res_q   <= '{ST_EMPTY, '0, '0, '0};
						state_q <= S_FINISH;
					end else begin
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (scan_last) begin
						state_q <= S_MOVE;
					end
				end
				S_MOVE: begin
					if (move_done) begin
						fill_q  <= fill_q - CW'(1);
						res_q   <= '{ST_DEQUEUED, best_payload_q, RANK_W'(best_rank_q),
						             OCC_W'(fill_q - CW'(1))};
						state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_IDLE) && req_valid) begin
			cmd_q     <= req.command;
			payload_q <= req.payload;
			rank_q    <= RANK_BITS'(req.rank);
		end
		if (state_q == S_EXEC) begin
			cmp_idx_q <= '0;
			first_q   <= 1'b1;
		end
		if (state_q == S_SCAN) begin
			cmp_idx_q      <= cmp_idx_q + AW'(1);
			first_q        <= 1'b0;
			best_idx_q     <= nb_idx;
			best_rank_q    <= nb_rank;
			best_payload_q <= nb_payload;
			// compaction starts at the winner, reading the entry behind it
			rdp_q          <= CW'(nb_idx) + CW'(1);
			wrp_q          <= nb_idx;
			pend_q         <= 1'b0;
		end
		if (state_q == S_MOVE) begin
			rdp_q  <= rdp_q + CW'(1);
			pend_q <= (rdp_q < fill_q);
			if (pend_q) begin
				wrp_q <= wrp_q + AW'(1);
			end
		end
	end

endmodule

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the stable minimum priority queue.
// ----------------------------------------------------------------------------
// A directed opening hits the empty and full cases, the extreme payloads and
// ranks, and ties between equal ranks. Random bursts follow: they fill the
// queue, drain it, or mix the two commands. Both handshakes idle at random.
// A shadow copy of the queue predicts every response, and the responses are
// checked field by field, in order.
module tb import mpqs_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CAPACITY   = 16;
	localparam int RANK_BITS  = 8;
	localparam int N_ITEMS    = 1350;
	localparam int DRAIN_WAIT = 2 * CAPACITY + 8;
	localparam int HANG_LIMIT = 4000;
	localparam int MAX_PRINTS = 40;

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      req_valid = 1'b0;
	logic      req_stall;
	in_item_t  req       = '0;
	logic      rsp_valid;
	logic      rsp_stall = 1'b0;
	out_item_t rsp;

	// commands waiting to go out, and responses owed by the queue
	in_item_t  cmd_backlog[$];
	out_item_t owed_rsp[$];

	// shadow copy of the queue contents, oldest entry at slot 0
	logic signed [PAYLOAD_W-1:0] shadow_payload[CAPACITY];
	logic [RANK_BITS-1:0]        shadow_rank[CAPACITY];
	int                          shadow_fill = 0;

	int gen_fill     = 0;
	int n_accepted   = 0;
	int n_responses  = 0;
	int n_mismatch   = 0;
	int n_enq        = 0;
	int n_deq        = 0;
	int n_full       = 0;
	int n_empty      = 0;
	int n_tie_wins   = 0;
	int peak_fill    = 0;
	int quiet_cycles = 0;

	min_priority_queue_stable #(
		.CAPACITY  (CAPACITY),
		.RANK_BITS (RANK_BITS)
	) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always #4 clk = ~clk;

	// apply one command to the shadow queue and return the response it owes
	function automatic out_item_t pq_apply(in_item_t cmd);
		out_item_t            r;
		int                   best;
		logic [RANK_BITS-1:0] rk;
		r = '0;
		rk = cmd.rank[RANK_BITS-1:0];
		if (cmd.command == CMD_ENQUEUE) begin
			if (shadow_fill >= CAPACITY) begin
				r.status = ST_FULL;
				n_full++;
			end else begin
				shadow_payload[shadow_fill] = cmd.payload;
				shadow_rank[shadow_fill] = rk;
				shadow_fill++;
				r.status = ST_ENQUEUED;
				n_enq++;
			end
		end else if (shadow_fill == 0) begin
			r.status = ST_EMPTY;
			n_empty++;
		end else begin
			best = 0;
			// strict compare keeps the oldest among equal ranks
			for (int i = 1; i < shadow_fill; i++) begin
				if (shadow_rank[i] < shadow_rank[best])
					best = i;
			end
			for (int i = best + 1; i < shadow_fill; i++) begin
				if (shadow_rank[i] == shadow_rank[best]) begin
					n_tie_wins++;
					break;
				end
			end
			r.status = ST_DEQUEUED;
			r.out_payload = shadow_payload[best];
			r.out_rank = RANK_W'(shadow_rank[best]);
			for (int i = best; i + 1 < shadow_fill; i++) begin
				shadow_payload[i] = shadow_payload[i + 1];
				shadow_rank[i] = shadow_rank[i + 1];
			end
			shadow_fill--;
			n_deq++;
		end
		if (shadow_fill > peak_fill)
			peak_fill = shadow_fill;
		r.occupancy = OCC_W'(shadow_fill);
		return r;
	endfunction

	task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
		if (n_mismatch < MAX_PRINTS)
			$display("[%0t] response %0d: %s got 0x%0h, want 0x%0h",
				$realtime, n_responses, field, got, want);
		n_mismatch++;
	endtask

	task automatic add_cmd(cmd_t c, logic signed [PAYLOAD_W-1:0] p, logic [RANK_W-1:0] r);
		in_item_t it;
		it.command = c;
		it.payload = p;
		it.rank = r;
		cmd_backlog.push_back(it);
		if (c == CMD_ENQUEUE && gen_fill < CAPACITY)
			gen_fill++;
		else if (c == CMD_DEQUEUE && gen_fill > 0)
			gen_fill--;
	endtask

	// narrow ranks make ties common, the rest spread over the full range or hit its two ends
	function automatic logic [RANK_W-1:0] pick_rank();
		int roll;
		roll = $urandom_range(0, 9);
		if (roll < 5)
			return RANK_W'($urandom_range(0, 3));
		else if (roll < 8)
			return RANK_W'($urandom_range(0, 255));
		else
			return (roll == 8) ? '0 : '1;
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			req <= '0;
		end else begin
			if (req_valid && !req_stall) begin
				owed_rsp.push_back(pq_apply(req));
				n_accepted++;
			end
			if (!req_valid || !req_stall) begin
				if (cmd_backlog.size() > 0 &&
						((n_accepted >= 500 && n_accepted < 800) ||
						$urandom_range(0, 99) >= 17)) begin
					req_valid <= 1'b1;
					req <= cmd_backlog.pop_front();
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin : mon
		out_item_t want;
		if (!arst_n) begin
			rsp_stall <= 1'b0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (owed_rsp.size() == 0) begin
					report_mismatch("unexpected response, status", 32'(rsp.status), 32'hx);
				end else begin
					want = owed_rsp.pop_front();
					if (rsp.status !== want.status)
						report_mismatch("status", 32'(rsp.status), 32'(want.status));
					if (rsp.out_payload !== want.out_payload)
						report_mismatch("out_payload", rsp.out_payload, want.out_payload);
					if (rsp.out_rank !== want.out_rank)
						report_mismatch("out_rank", 32'(rsp.out_rank), 32'(want.out_rank));
					if (rsp.occupancy !== want.occupancy)
						report_mismatch("occupancy", 32'(rsp.occupancy),
							32'(want.occupancy));
				end
				n_responses++;
			end
			rsp_stall <= !(n_responses >= 500 && n_responses < 800) &&
				($urandom_range(0, 99) < 17);
		end
	end

	// watchdog on cycles with no item moving on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= HANG_LIMIT) begin
				$display("[%0t] no progress for %0d cycles", $realtime, HANG_LIMIT);
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	initial begin : stim
		int target;
		int kind;
		int n_total;

		// empty dequeue, fill with extremes and ties, refused enqueue, partial drain
		add_cmd(CMD_DEQUEUE, 32'sh0, 8'd0);
		add_cmd(CMD_ENQUEUE, 32'sh7fffffff, 8'd255);
		add_cmd(CMD_ENQUEUE, 32'sh80000000, 8'd0);
		add_cmd(CMD_ENQUEUE, 32'sh0, 8'd128);
		add_cmd(CMD_ENQUEUE, -32'sd1, 8'd0);
		add_cmd(CMD_ENQUEUE, 32'sh55555555, 8'd255);
		add_cmd(CMD_ENQUEUE, 32'shaaaaaaaa, 8'd1);
		add_cmd(CMD_ENQUEUE, 32'sd7001, 8'd7);
		add_cmd(CMD_ENQUEUE, 32'sd7002, 8'd7);
		add_cmd(CMD_ENQUEUE, 32'sd7003, 8'd7);
		add_cmd(CMD_ENQUEUE, 32'sd254, 8'd254);
		add_cmd(CMD_ENQUEUE, -32'sd2, 8'd1);
		add_cmd(CMD_ENQUEUE, 32'sd100, 8'd0);
		add_cmd(CMD_ENQUEUE, 32'sd200, 8'd200);
		add_cmd(CMD_ENQUEUE, 32'sd3, 8'd3);
		add_cmd(CMD_ENQUEUE, 32'sd7004, 8'd7);
		add_cmd(CMD_ENQUEUE, 32'sh0f0f0f0f, 8'd255);
		add_cmd(CMD_ENQUEUE, 32'sh12345678, 8'd0);
		repeat (7)
			add_cmd(CMD_DEQUEUE, $urandom, 8'd0);

		// random bursts: fill toward full, drain toward empty, or plain noise
		while (cmd_backlog.size() < N_ITEMS) begin
			kind = $urandom_range(0, 9);
			if (kind < 4) begin
				target = $urandom_range(gen_fill, CAPACITY);
				while (gen_fill < target) begin
					if (gen_fill > 0 && $urandom_range(0, 5) == 0)
						add_cmd(CMD_DEQUEUE, $urandom, pick_rank());
					else
						add_cmd(CMD_ENQUEUE, $urandom, pick_rank());
				end
				if (gen_fill == CAPACITY && $urandom_range(0, 2) == 0)
					repeat ($urandom_range(1, 2))
						add_cmd(CMD_ENQUEUE, $urandom, pick_rank());
			end else if (kind < 8) begin
				target = $urandom_range(0, gen_fill);
				while (gen_fill > target) begin
					if ($urandom_range(0, 5) == 0)
						add_cmd(CMD_ENQUEUE, $urandom, pick_rank());
					else
						add_cmd(CMD_DEQUEUE, $urandom, pick_rank());
				end
				if (gen_fill == 0 && $urandom_range(0, 2) == 0)
					repeat ($urandom_range(1, 2))
						add_cmd(CMD_DEQUEUE, $urandom, pick_rank());
			end else begin
				repeat ($urandom_range(1, 16))
					add_cmd(cmd_t'($urandom_range(0, 1)), $urandom, pick_rank());
			end
		end
		n_total = cmd_backlog.size();

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		wait (n_accepted == n_total && owed_rsp.size() == 0);
		repeat (DRAIN_WAIT) @(posedge clk);

		$display("%0d commands, %0d responses: %0d enqueued, %0d refused full, %0d dequeued",
			n_accepted, n_responses, n_enq, n_full, n_deq);
		$display("%0d dequeues on empty, %0d ties broken by age, peak occupancy %0d",
			n_empty, n_tie_wins, peak_fill);
		if (n_mismatch == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
